// ===== hw/rtl/tkn_pkg.sv =====
// Shared types and constants for the top-k nearest scan.
// Used by tkn_score, tkn_cell and capped_topk_nearest_scan; depends on nothing.
`timescale 1ns / 1ps

package tkn_pkg;

   localparam int MAX_DIM   = 256;
   localparam int MAX_K     = 32;
   localparam int ELEM_BITS = 16;

   localparam int CMD_BITS       = 2;
   localparam int ID_BITS        = 32;
   localparam int IDX_BITS       = 8;
   localparam int DIM_BITS       = 9;
   localparam int TOP_COUNT_BITS = 6;
   localparam int LIMIT_BITS     = 24;
   localparam int ACC_BITS       = 41;
   localparam int DIST_BITS      = 40;
   localparam int SQ_BITS        = 2 * ELEM_BITS;
   localparam int K_BITS         = $clog2(MAX_K + 1);
   localparam int ADDR_BITS      = $clog2(MAX_DIM);
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CMD_BITS-1:0] CMD_QUERY     = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CANDIDATE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FINISH    = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_COUNT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCAN_LIMIT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMENSION  = 2'd2;

   localparam logic [TOP_COUNT_BITS-1:0] TOP_COUNT_RESET  = 6'd10;
   localparam logic [LIMIT_BITS-1:0]     SCAN_LIMIT_RESET = 24'hFFFFFF;
   localparam logic [DIM_BITS-1:0]       DIMENSION_RESET  = 9'd128;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [ACC_BITS-1:0] distance;
   } entry_type;

   typedef struct packed {
      logic                valid;
      logic                finish;
      logic [ID_BITS-1:0]  id;
      logic [ACC_BITS-1:0] distance;
   } offer_type;

   typedef struct packed {
      logic                insert;
      logic                shift;
      logic [ID_BITS-1:0]  id;
      logic [ACC_BITS-1:0] distance;
   } cell_ctl_type;

   typedef enum logic {
      DRAIN_IDLE,
      DRAIN_RUN
   } drain_state_type;

endpackage

// ===== hw/rtl/capped_topk_nearest_scan.sv =====
// Top level of the top-k nearest scan: configuration, sorted cell row, result drain.
// Depends on tkn_pkg, tkn_score and tkn_cell.
//
// Use: write top_count, scan_limit and dimension on the csr_ channel while idle
// (csr_ready is always high). Send query elements (cmd 0), then candidate
// elements (cmd 1) tagged with their id, then a finish beat (cmd 2).
// Element beats are taken one per cycle while req_stall is low. A candidate's last
// element passes the s1, s2 and offer registers to the sorted row and is inserted by
// the row of cells, which compare in parallel and shift towards the tail.
// A finish beat passes the same registers; the row then shifts its entries towards
// the head one per result beat, into the rsp_ output register.
// A finish with n kept entries holds req_stall high until max(n,1) result beats are
// out, receiver stalls included; one result beat goes out per cycle while rsp_stall
// stays low. The first result enters the rsp_ register once the finish reaches the
// drain state. With an empty list one invalid result marked last appears.
// rsp_stall holds the output register and, during a drain, the whole row.
// Reset clears the pipeline, the list fill, the scan count and the registers
// to their defaults; the query store keeps no reset value.
`timescale 1ns / 1ps

module capped_topk_nearest_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tkn_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [tkn_pkg::ID_BITS-1:0]          req_vector_id,
   input  logic [tkn_pkg::IDX_BITS-1:0]         req_elem_index,
   input  logic signed [tkn_pkg::ELEM_BITS-1:0] req_elem_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tkn_pkg::ID_BITS-1:0]          rsp_result_id,
   output logic [tkn_pkg::DIST_BITS-1:0]        rsp_result_distance,
   output logic                                 rsp_result_valid,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tkn_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [tkn_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import tkn_pkg::*;

   logic [TOP_COUNT_BITS-1:0] top_count_ff;
   logic [LIMIT_BITS-1:0]     scan_limit_ff;
   logic [DIM_BITS-1:0]       dimension_ff;
   logic [DIM_BITS-1:0]       dim_eff;
   logic [K_BITS-1:0]         k_eff;

   drain_state_type state_ff, state_in;
   logic            advance;
   logic            start_drain;
   logic            out_free;
   logic            emit;
   logic            emit_empty;

   logic [K_BITS-1:0] kept_fill_ff, kept_fill_in;
   logic [K_BITS-1:0] fill_eff;
   logic [K_BITS-1:0] remain_ff, remain_in;

   offer_type         offer;
   cell_ctl_type      ctl;
   logic [MAX_K-1:0]  take;
   logic [MAX_K-1:0]  prev_take;
   logic [MAX_K-1:0]  occupied;
   logic [MAX_K-1:0]  in_range;
   entry_type         cells      [MAX_K];
   entry_type         prev_entry [MAX_K];
   entry_type         next_entry [MAX_K];

   logic                  rsp_valid_ff;
   logic [ID_BITS-1:0]    rsp_id_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;
   logic                  rsp_rvalid_ff;
   logic                  rsp_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_COUNT_RESET;
         scan_limit_ff <= SCAN_LIMIT_RESET;
         dimension_ff <= DIMENSION_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOP_COUNT:  top_count_ff <= csr_data[TOP_COUNT_BITS-1:0];
            CSR_SCAN_LIMIT: scan_limit_ff <= csr_data[LIMIT_BITS-1:0];
            CSR_DIMENSION:  dimension_ff <= csr_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (dimension_ff == '0) begin
         dim_eff = DIM_BITS'(1);
      end else if (dimension_ff > DIM_BITS'(MAX_DIM)) begin
         dim_eff = DIM_BITS'(MAX_DIM);
      end else begin
         dim_eff = dimension_ff;
      end
      if (top_count_ff == '0) begin
         k_eff = K_BITS'(1);
      end else if (top_count_ff > TOP_COUNT_BITS'(MAX_K)) begin
         k_eff = K_BITS'(MAX_K);
      end else begin
         k_eff = K_BITS'(top_count_ff);
      end
   end

   assign req_stall = (state_ff != DRAIN_IDLE);

   tkn_score u_score (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .accept     (req_valid && !req_stall),
      .cmd        (req_cmd),
      .vector_id  (req_vector_id),
      .elem_index (req_elem_index),
      .elem_value (req_elem_value),
      .dim_eff    (dim_eff),
      .scan_limit (scan_limit_ff),
      .offer      (offer)
   );

   assign fill_eff = (kept_fill_ff < k_eff) ? kept_fill_ff : k_eff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DRAIN_IDLE: begin
            if (start_drain) begin
               state_in = DRAIN_RUN;
            end
         end
         DRAIN_RUN: begin
            if (out_free && (remain_ff <= K_BITS'(1))) begin
               state_in = DRAIN_IDLE;
            end
         end
         default: state_in = DRAIN_IDLE;
      endcase
   end

   always_comb begin
      advance = 1'b0;
      start_drain = 1'b0;
      emit = 1'b0;
      emit_empty = 1'b0;
      ctl.insert = 1'b0;
      ctl.shift = 1'b0;
      ctl.id = offer.id;
      ctl.distance = offer.distance;
      unique case (state_ff)
         DRAIN_IDLE: begin
            advance = 1'b1;
            start_drain = offer.valid && offer.finish;
            ctl.insert = offer.valid && !offer.finish && (|take);
         end
         DRAIN_RUN: begin
            emit = out_free;
            emit_empty = out_free && (remain_ff == '0);
            ctl.shift = out_free && (remain_ff != '0);
         end
         default: ;
      endcase
   end

   always_comb begin
      kept_fill_in = kept_fill_ff;
      remain_in = remain_ff;
      if (start_drain) begin
         kept_fill_in = '0;
         remain_in = fill_eff;
      end else if (ctl.insert) begin
         kept_fill_in = (fill_eff == k_eff) ? k_eff : fill_eff + K_BITS'(1);
      end
      if (ctl.shift) begin
         remain_in = remain_ff - K_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DRAIN_IDLE;
         kept_fill_ff <= '0;
         remain_ff <= '0;
      end else begin
         state_ff <= state_in;
         kept_fill_ff <= kept_fill_in;
         remain_ff <= remain_in;
      end
   end

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_take[i] = 1'b0;
         assign prev_entry[i] = cells[i];
      end else begin : g_body
         assign prev_take[i] = take[i-1];
         assign prev_entry[i] = cells[i-1];
      end
      if (i == MAX_K - 1) begin : g_tail
         assign next_entry[i] = cells[i];
      end else begin : g_inner
         assign next_entry[i] = cells[i+1];
      end
      assign occupied[i] = K_BITS'(i) < fill_eff;
      assign in_range[i] = K_BITS'(i) < k_eff;

      tkn_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied[i]),
         .in_range   (in_range[i]),
         .prev_take  (prev_take[i]),
         .prev_entry (prev_entry[i]),
         .next_entry (next_entry[i]),
         .take       (take[i]),
         .entry      (cells[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_empty) begin
            rsp_id_ff <= '0;
            rsp_dist_ff <= '0;
            rsp_rvalid_ff <= 1'b0;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_id_ff <= cells[0].id;
            rsp_dist_ff <= cells[0].distance[ACC_BITS-1] ? {DIST_BITS{1'b1}}
                                                         : cells[0].distance[DIST_BITS-1:0];
            rsp_rvalid_ff <= 1'b1;
            rsp_last_ff <= (remain_ff == K_BITS'(1));
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_result_distance = rsp_dist_ff;
   assign rsp_result_valid = rsp_rvalid_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_drain_entry: assert property (@(posedge clock) disable iff (reset)
      (start_drain) |=> (state_ff == DRAIN_RUN) && (kept_fill_ff == '0))
      else $error("finish did not start a drain with the list cleared");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |-> rsp_last)
      else $error("invalid result not marked last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (kept_fill_ff <= K_BITS'(MAX_K)) && (remain_ff <= K_BITS'(MAX_K)))
      else $error("list fill or drain count beyond row length");

   a_no_insert_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN_RUN) |-> !ctl.insert && (kept_fill_ff == '0))
      else $error("list changed during a drain");
`endif

endmodule

// ===== hw/rtl/tkn_score.sv =====
// Scoring front end: query store, squared difference and distance accumulator.
// Depends on tkn_pkg; feeds finished candidates and finish beats to the cell chain.
`timescale 1ns / 1ps

module tkn_score (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            accept,
   input  logic [tkn_pkg::CMD_BITS-1:0]    cmd,
   input  logic [tkn_pkg::ID_BITS-1:0]     vector_id,
   input  logic [tkn_pkg::IDX_BITS-1:0]    elem_index,
   input  logic signed [tkn_pkg::ELEM_BITS-1:0] elem_value,
   input  logic [tkn_pkg::DIM_BITS-1:0]    dim_eff,
   input  logic [tkn_pkg::LIMIT_BITS-1:0]  scan_limit,
   output tkn_pkg::offer_type              offer
);
   import tkn_pkg::*;

   logic [ELEM_BITS-1:0] query_mem [MAX_DIM];

   logic                 idx_ok;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_finish_ff;
   logic [IDX_BITS-1:0]  s1_idx_ff;
   logic [ID_BITS-1:0]   s1_id_ff;
   logic [ELEM_BITS-1:0] s1_val_ff;
   logic [ELEM_BITS-1:0] s1_query_ff;

   logic signed [ELEM_BITS:0] diff;
   logic [ELEM_BITS-1:0]      abs_diff;

   logic                 s2_valid_ff;
   logic                 s2_finish_ff;
   logic                 s2_first_ff;
   logic                 s2_end_ff;
   logic [ID_BITS-1:0]   s2_id_ff;
   logic [SQ_BITS-1:0]   s2_sq_ff;

   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [ACC_BITS-1:0]   acc_base;
   logic [ACC_BITS:0]     acc_sum;
   logic [LIMIT_BITS-1:0] scanned_ff, scanned_in;
   logic                  score_it;
   offer_type             offer_ff, offer_in;

   assign idx_ok = {1'b0, elem_index} < dim_eff;
   assign s1_valid_in = accept && (((cmd == CMD_CANDIDATE) && idx_ok) || (cmd == CMD_FINISH));

   always_ff @(posedge clock) begin
      if (accept && (cmd == CMD_QUERY) && idx_ok) begin
         query_mem[elem_index[ADDR_BITS-1:0]] <= elem_value;
      end
      if (advance) begin
         s1_query_ff <= query_mem[elem_index[ADDR_BITS-1:0]];
         s1_finish_ff <= (cmd == CMD_FINISH);
         s1_idx_ff <= elem_index;
         s1_id_ff <= vector_id;
         s1_val_ff <= elem_value;
      end
   end

   assign diff = {s1_query_ff[ELEM_BITS-1], s1_query_ff} - {s1_val_ff[ELEM_BITS-1], s1_val_ff};
   assign abs_diff = diff[ELEM_BITS] ? ELEM_BITS'(-diff) : diff[ELEM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_finish_ff <= s1_finish_ff;
         s2_first_ff <= (s1_idx_ff == '0);
         s2_end_ff <= ({1'b0, s1_idx_ff} == (dim_eff - DIM_BITS'(1)));
         s2_id_ff <= s1_id_ff;
         s2_sq_ff <= abs_diff * abs_diff;
      end
   end

   assign acc_base = s2_first_ff ? '0 : acc_ff;
   assign acc_sum = {1'b0, acc_base} + (ACC_BITS + 1)'(s2_sq_ff);
   assign score_it = s2_valid_ff && !s2_finish_ff && s2_end_ff && (scanned_ff < scan_limit);

   always_comb begin
      acc_in = acc_ff;
      scanned_in = scanned_ff;
      offer_in.valid = s2_valid_ff && (s2_finish_ff || score_it);
      offer_in.finish = s2_finish_ff;
      offer_in.id = s2_id_ff;
      offer_in.distance = acc_ff;
      if (s2_valid_ff && !s2_finish_ff) begin
         acc_in = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];
         offer_in.distance = acc_in;
      end
      if (score_it) begin
         scanned_in = scanned_ff + LIMIT_BITS'(1);
      end
      if (s2_valid_ff && s2_finish_ff) begin
         scanned_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         offer_ff.valid <= 1'b0;
         acc_ff <= '0;
         scanned_ff <= '0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         offer_ff <= offer_in;
         acc_ff <= acc_in;
         scanned_ff <= scanned_in;
      end
   end

   assign offer = offer_ff;

endmodule

// ===== hw/rtl/tkn_cell.sv =====
// One cell of the sorted list: holds an entry, inserts or shifts from a neighbour.
// Depends on tkn_pkg; instantiated in a row by capped_topk_nearest_scan.
`timescale 1ns / 1ps

module tkn_cell (
   input  logic                  clock,
   input  tkn_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  logic                  in_range,
   input  logic                  prev_take,
   input  tkn_pkg::entry_type    prev_entry,
   input  tkn_pkg::entry_type    next_entry,
   output logic                  take,
   output tkn_pkg::entry_type    entry
);
   import tkn_pkg::*;

   entry_type entry_ff, entry_in;

   // strict compare: an equal distance stays ahead
   assign take = in_range && (!occupied || (entry_ff.distance > ctl.distance));

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && take) begin
         if (prev_take) begin
            entry_in = prev_entry;
         end else begin
            entry_in.id = ctl.id;
            entry_in.distance = ctl.distance;
         end
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== bench/capped_topk_nearest_scan_check.sv =====
// Result checker for capped_topk_nearest_scan: watches the req_, rsp_ and csr_ channels,
// keeps its own copy of the query, the sorted nearest list and the registers, and
// compares every result beat with the oldest one due. Depends on tkn_pkg.
`timescale 1ns / 1ps

module capped_topk_nearest_scan_check
   import tkn_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [CMD_BITS-1:0]         req_cmd,
   input  logic [ID_BITS-1:0]          req_vector_id,
   input  logic [IDX_BITS-1:0]         req_elem_index,
   input  logic signed [ELEM_BITS-1:0] req_elem_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ID_BITS-1:0]          rsp_result_id,
   input  logic [DIST_BITS-1:0]        rsp_result_distance,
   input  logic                        rsp_result_valid,
   input  logic                        rsp_last,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data,
   output int                          failures,
   output int                          pending,
   output int                          results_checked
);

   localparam logic [ACC_BITS-1:0]  ACC_CAP  = '1;
   localparam logic [DIST_BITS-1:0] DIST_CAP = '1;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [DIST_BITS-1:0] distance;
      logic                 hit;
      logic                 last;
   } neighbour_beat_type;

   neighbour_beat_type          due_neighbours[$];
   logic signed [ELEM_BITS-1:0] query_elems [MAX_DIM];
   logic [ID_BITS-1:0]          near_ids [MAX_K];
   logic [ACC_BITS-1:0]         near_dists [MAX_K];
   logic [ACC_BITS-1:0]         dist_sum;
   logic [LIMIT_BITS-1:0]       scored;
   int                          near_fill;
   logic [TOP_COUNT_BITS-1:0]   top_count_reg;
   logic [LIMIT_BITS-1:0]       scan_limit_reg;
   logic [DIM_BITS-1:0]         dimension_reg;
   int                          mismatches;
   int                          checked;

   function automatic int vector_span();
      if (dimension_reg == 0) return 1;
      if (dimension_reg > MAX_DIM) return MAX_DIM;
      return int'(dimension_reg);
   endfunction

   function automatic int keep_size();
      if (top_count_reg == 0) return 1;
      if (top_count_reg > MAX_K) return MAX_K;
      return int'(top_count_reg);
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Ties keep the earlier candidate ahead; the tail drops off when full.
   task automatic rank_candidate(input logic [ID_BITS-1:0] id, input logic [ACC_BITS-1:0] d);
      int k;
      int n;
      int pos;
      int i;
      k = keep_size();
      n = near_fill < k ? near_fill : k;
      pos = 0;
      while (pos < n && near_dists[pos] <= d) pos++;
      if (pos < k) begin
         if (n == k) n = k - 1;
         for (i = n; i > pos; i--) begin
            near_ids[i] = near_ids[i-1];
            near_dists[i] = near_dists[i-1];
         end
         near_ids[pos] = id;
         near_dists[pos] = d;
         near_fill = n + 1;
      end
   endtask

   task automatic take_request(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                               input logic [IDX_BITS-1:0] idx,
                               input logic signed [ELEM_BITS-1:0] val);
      int                 span;
      int                 n;
      int                 i;
      longint             diff;
      logic [63:0]        square;
      neighbour_beat_type beat;
      span = vector_span();
      case (cmd)
         CMD_QUERY: begin
            if (idx < span) query_elems[idx] = val;
         end
         CMD_CANDIDATE: begin
            if (idx < span) begin
               if (idx == 0) dist_sum = '0;
               diff = longint'(query_elems[idx]) - longint'(val);
               if (diff < 0) diff = -diff;
               square = diff * diff;
               if (square > ACC_CAP) square = ACC_CAP;
               if (64'(ACC_CAP) - 64'(dist_sum) < square) dist_sum = ACC_CAP;
               else dist_sum = dist_sum + square[ACC_BITS-1:0];
               if (idx == span - 1 && scored < scan_limit_reg) begin
                  rank_candidate(id, dist_sum);
                  scored++;
               end
            end
         end
         CMD_FINISH: begin
            n = near_fill < keep_size() ? near_fill : keep_size();
            near_fill = 0;
            scored = '0;
            if (n == 0) begin
               beat = '{id: '0, distance: '0, hit: 1'b0, last: 1'b1};
               due_neighbours.push_back(beat);
            end
            for (i = 0; i < n; i++) begin
               beat.id = near_ids[i];
               beat.distance = near_dists[i] > ACC_BITS'(DIST_CAP) ? DIST_CAP
                                                                   : near_dists[i][DIST_BITS-1:0];
               beat.hit = 1'b1;
               beat.last = (i + 1 == n);
               due_neighbours.push_back(beat);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_neighbour();
      neighbour_beat_type want;
      if (due_neighbours.size() == 0) begin
         report($sformatf("result beat with nothing due: id %0h distance %0h",
                          rsp_result_id, rsp_result_distance));
      end else begin
         want = due_neighbours.pop_front();
         if (rsp_result_id !== want.id)
            report($sformatf("result %0d id: got %0h, expected %0h",
                             checked, rsp_result_id, want.id));
         if (rsp_result_distance !== want.distance)
            report($sformatf("result %0d distance: got %0h, expected %0h",
                             checked, rsp_result_distance, want.distance));
         if (rsp_result_valid !== want.hit)
            report($sformatf("result %0d valid flag: got %b, expected %b",
                             checked, rsp_result_valid, want.hit));
         if (rsp_last !== want.last)
            report($sformatf("result %0d last flag: got %b, expected %b",
                             checked, rsp_last, want.last));
         checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_neighbours.delete();
         for (int i = 0; i < MAX_DIM; i++) query_elems[i] = '0;
         near_fill = 0;
         dist_sum = '0;
         scored = '0;
         top_count_reg = TOP_COUNT_RESET;
         scan_limit_reg = SCAN_LIMIT_RESET;
         dimension_reg = DIMENSION_RESET;
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_neighbour();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOP_COUNT:  top_count_reg = csr_data[TOP_COUNT_BITS-1:0];
               CSR_SCAN_LIMIT: scan_limit_reg = csr_data[LIMIT_BITS-1:0];
               CSR_DIMENSION:  dimension_reg = csr_data[DIM_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            take_request(req_cmd, req_vector_id, req_elem_index, req_elem_value);
      end
      failures <= mismatches;
      pending <= due_neighbours.size();
      results_checked <= checked;
   end

endmodule

// ===== bench/capped_topk_nearest_scan_test.sv =====
// Top of the capped_topk_nearest_scan bench: clock, reset, stimulus and verdict.
// Drives query, candidate and finish beats plus register writes; checking is done
// by capped_topk_nearest_scan_check. Depends on tkn_pkg and the block itself.
`timescale 1ns / 1ps

module capped_topk_nearest_scan_test;
   import tkn_pkg::*;

   localparam logic [CMD_BITS-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
   localparam logic [ELEM_BITS-1:0] ELEM_MAX = ~ELEM_MIN;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 80;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_BITS-1:0]      req_cmd = CMD_QUERY;
   logic [ID_BITS-1:0]       req_vector_id = '0;
   logic [IDX_BITS-1:0]      req_elem_index = '0;
   logic [ELEM_BITS-1:0]     req_elem_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ID_BITS-1:0]       rsp_result_id;
   logic [DIST_BITS-1:0]     rsp_result_distance;
   logic                     rsp_result_valid;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_TOP_COUNT;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int   failures;
   int   pending;
   int   results_checked;
   int   send_idle_pct = 11;
   int   recv_idle_pct = 78;
   int   holds_asked = 0;
   int   beats_sent = 0;
   int   noise_beats = 0;
   int   finishes_sent = 0;
   int   cur_dim = 128;
   bit   value_narrow = 1'b0;

   capped_topk_nearest_scan u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_vector_id       (req_vector_id),
      .req_elem_index      (req_elem_index),
      .req_elem_value      (req_elem_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_distance (rsp_result_distance),
      .rsp_result_valid    (rsp_result_valid),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   capped_topk_nearest_scan_check u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_vector_id       (req_vector_id),
      .req_elem_index      (req_elem_index),
      .req_elem_value      (req_elem_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_distance (rsp_result_distance),
      .rsp_result_valid    (rsp_result_valid),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .failures            (failures),
      .pending             (pending),
      .results_checked     (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("run timed out with %0d result beats still due", pending);
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random stalls, or a long hold when one is asked for.
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_asked > holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic send_beat(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                            input logic [IDX_BITS-1:0] idx, input logic [ELEM_BITS-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_vector_id <= id;
      req_elem_index <= idx;
      req_elem_value <= val;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (cmd == CMD_FINISH) finishes_sent++;
   endtask

   // Drop valid and wait until every result is out and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DIMENSION) begin
         if (data[DIM_BITS-1:0] == 0) cur_dim = 1;
         else if (data[DIM_BITS-1:0] > MAX_DIM) cur_dim = MAX_DIM;
         else cur_dim = int'(data[DIM_BITS-1:0]);
      end
   endtask

   function automatic logic [ELEM_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         default: return value_narrow ? ELEM_BITS'($urandom_range(0, 4) - 2)
                                      : ELEM_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_top_count();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_BITS'(1);
         2: return CSR_DATA_BITS'(MAX_K);
         3: return CSR_DATA_BITS'($urandom_range(MAX_K + 1, 63));
         default: return CSR_DATA_BITS'($urandom_range(2, MAX_K - 1));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_scan_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_BITS'(1);
         2: return CSR_DATA_BITS'($urandom_range(2, 6));
         3: return SCAN_LIMIT_RESET;
         default: return CSR_DATA_BITS'($urandom_range(7, 20));
      endcase
   endfunction

   // Beats the block ignores: the spare command and indices past the dimension.
   task automatic send_noise();
      noise_beats++;
      if (cur_dim >= MAX_DIM || $urandom_range(0, 2) == 0)
         send_beat(CMD_UNUSED, $urandom, IDX_BITS'($urandom), ELEM_BITS'($urandom));
      else if ($urandom_range(0, 1) == 0)
         send_beat(CMD_QUERY, $urandom, IDX_BITS'($urandom_range(cur_dim, MAX_DIM - 1)),
                   ELEM_BITS'($urandom));
      else
         send_beat(CMD_CANDIDATE, $urandom, IDX_BITS'($urandom_range(cur_dim, MAX_DIM - 1)),
                   ELEM_BITS'($urandom));
   endtask

   task automatic send_candidate(input logic [ID_BITS-1:0] id);
      int i;
      if ($urandom_range(0, 7) == 0) begin
         // broken vector: skipped, repeated and shuffled elements
         repeat ($urandom_range(1, cur_dim + 1))
            send_beat(CMD_CANDIDATE, id, IDX_BITS'($urandom_range(0, cur_dim - 1)),
                      pick_value());
      end else begin
         for (i = 0; i < cur_dim; i++) send_beat(CMD_CANDIDATE, id, IDX_BITS'(i), pick_value());
      end
   endtask

   task automatic run_query();
      int               i;
      int               count;
      logic [ID_BITS-1:0] id;
      value_narrow = $urandom_range(0, 1);
      for (i = 0; i < cur_dim; i++) send_beat(CMD_QUERY, $urandom, IDX_BITS'(i), pick_value());
      count = $urandom_range(1, 12);
      id = $urandom;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         if ($urandom_range(0, 3) != 0) id = $urandom;
         send_candidate(id);
         if ($urandom_range(0, 15) == 0) write_reg(CSR_TOP_COUNT, pick_top_count());
      end
      send_beat(CMD_FINISH, $urandom, IDX_BITS'($urandom), ELEM_BITS'($urandom));
   endtask

   task automatic run_random(input int beats);
      int start;
      start = beats_sent - noise_beats;
      while (beats_sent - noise_beats - start < beats) begin
         if ($urandom_range(0, 1) == 0) begin
            write_reg(CSR_DIMENSION, $urandom_range(0, 1) == 0 ? '0
                                     : CSR_DATA_BITS'($urandom_range(1, 6)));
            write_reg(CSR_TOP_COUNT, pick_top_count());
            write_reg(CSR_SCAN_LIMIT, pick_scan_limit());
         end
         run_query();
      end
   endtask

   task automatic run_directed();
      // empty list at reset, then the spare command
      send_beat(CMD_FINISH, '0, '0, '0);
      send_beat(CMD_UNUSED, '1, '1, '1);
      // dimension zero acts as one; ties keep the earlier id
      write_reg(CSR_DIMENSION, 0);
      send_beat(CMD_QUERY, '0, 0, ELEM_MIN);
      send_beat(CMD_QUERY, '0, 200, 7);
      send_beat(CMD_CANDIDATE, '1, 0, ELEM_MAX);
      send_beat(CMD_CANDIDATE, '0, 0, ELEM_MIN);
      send_beat(CMD_CANDIDATE, 5, 255, 3);
      send_beat(CMD_CANDIDATE, 9, 0, ELEM_MIN);
      send_beat(CMD_FINISH, '0, '0, '0);
      // full dimension, sparse elements
      write_reg(CSR_DIMENSION, CSR_DATA_BITS'(MAX_DIM));
      send_beat(CMD_QUERY, '0, 0, 100);
      send_beat(CMD_QUERY, '0, IDX_BITS'(MAX_DIM - 1), ELEM_BITS'(-7));
      send_beat(CMD_CANDIDATE, 32'hA5A5A5A5, 0, 100);
      send_beat(CMD_CANDIDATE, 32'hA5A5A5A5, IDX_BITS'(MAX_DIM - 1), ELEM_BITS'(-7));
      send_beat(CMD_CANDIDATE, 32'h5A5A5A5A, IDX_BITS'(MAX_DIM - 1), 0);
      send_beat(CMD_FINISH, '0, '0, '0);
      // nothing scored with a zero scan limit
      write_reg(CSR_SCAN_LIMIT, 0);
      write_reg(CSR_TOP_COUNT, 0);
      write_reg(CSR_DIMENSION, 511);
      send_beat(CMD_CANDIDATE, 7, IDX_BITS'(MAX_DIM - 1), 1);
      send_beat(CMD_FINISH, '0, '0, '0);
      write_reg(CSR_DIMENSION, 1);
      write_reg(CSR_SCAN_LIMIT, 1);
      write_reg(CSR_TOP_COUNT, 63);
      send_beat(CMD_CANDIDATE, 11, 0, 50);
      send_beat(CMD_CANDIDATE, 12, 0, 100);
      send_beat(CMD_FINISH, '0, '0, '0);
      write_reg(CSR_TOP_COUNT, 1);
      write_reg(CSR_SCAN_LIMIT, 2);
      send_beat(CMD_CANDIDATE, 21, 0, ELEM_MIN);
      send_beat(CMD_CANDIDATE, 22, 0, 99);
      send_beat(CMD_FINISH, '0, '0, '0);
      // lower the list size while entries are held
      write_reg(CSR_TOP_COUNT, CSR_DATA_BITS'(MAX_K));
      write_reg(CSR_SCAN_LIMIT, SCAN_LIMIT_RESET);
      send_beat(CMD_CANDIDATE, 31, 0, 103);
      send_beat(CMD_CANDIDATE, 32, 0, 100);
      send_beat(CMD_CANDIDATE, 33, 0, 101);
      write_reg(CSR_TOP_COUNT, 2);
      send_beat(CMD_FINISH, '0, '0, '0);
   endtask

   // Hold the receiver while the sender keeps offering, so the block backs up.
   task automatic run_pressure();
      write_reg(CSR_DIMENSION, 2);
      write_reg(CSR_TOP_COUNT, CSR_DATA_BITS'(MAX_K));
      write_reg(CSR_SCAN_LIMIT, SCAN_LIMIT_RESET);
      holds_asked++;
      repeat (3) run_query();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      cur_dim = int'(DIMENSION_RESET);
      run_directed();
      run_random(PHASE_BEATS);
      send_idle_pct = 78;
      recv_idle_pct = 11;
      run_random(PHASE_BEATS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_pressure();
      run_random(PHASE_BEATS);
      settle();
      $display("Covered %0d request beats, %0d finish commands and %0d result beats",
               beats_sent, finishes_sent, results_checked);
      $display("over three idling profiles, a long output hold, extreme values and registers");
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
